[design/mrtu_pkg.sv]
// Shared types, codes and the byte-wide CRC step for the Modbus RTU frame checker.
`timescale 1ns / 1ps

package mrtu_pkg;

    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'hA001;
    localparam int          MIN_FRAME_BYTES     = 4;
    localparam logic [7:0]  BROADCAST_ADDR      = 8'h00;
    localparam logic [7:0]  OWN_ADDR_RESET      = 8'h01;
    localparam logic [7:0]  FUNC_READ_HOLDING   = 8'h03;
    localparam logic [7:0]  FUNC_WRITE_MULTIPLE = 8'h10;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_CRC   = 3'd2;
    localparam logic [2:0] ST_ADDR  = 3'd3;
    localparam logic [2:0] ST_LONG  = 3'd4;

    localparam logic [1:0] KIND_READ_HOLDING   = 2'd0;
    localparam logic [1:0] KIND_WRITE_MULTIPLE = 2'd1;
    localparam logic [1:0] KIND_OTHER          = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic [2:0] frame_status;
        logic [7:0] slave_address;
        logic [7:0] function_code;
        logic [1:0] request_kind;
        logic       is_broadcast;
    } t_out_word;

    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        a = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (a[0]) begin
                a = (a >> 1) ^ CRC_POLY;
            end else begin
                a = a >> 1;
            end
        end
        return a;
    endfunction

endpackage

[design/mrtu_frame_track.sv]
// Per-frame state: CRC, two-byte delay, byte count, captured header and the verdict.
`timescale 1ns / 1ps

module mrtu_frame_track
    import mrtu_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_in_word   i_in_word,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output t_out_word  o_result
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CntMax   = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CntShort = CNT_W'(MIN_FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] CntOne   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CntTwo   = CNT_W'(2);

    logic [7:0]       r_own_addr;
    logic [15:0]      r_crc;
    logic [7:0]       r_held0;
    logic [7:0]       r_held1;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_addr;
    logic [7:0]       r_func;

    logic [7:0]  addr_cur;
    logic [7:0]  func_cur;
    logic [15:0] crc_cur;
    logic [15:0] rx_crc;
    logic [2:0]  status;
    logic [1:0]  kind;

    always_comb begin
        addr_cur = r_addr;
        func_cur = r_func;
        if (r_count == '0) begin
            addr_cur = i_in_word.rx_byte;
            func_cur = 8'h00;
        end else if (r_count == CntOne) begin
            func_cur = i_in_word.rx_byte;
        end
        crc_cur = (r_count >= CntTwo) ? crc_feed(r_crc, r_held0) : r_crc;
        rx_crc  = {i_in_word.rx_byte, r_held1};

        if (r_count < CntShort) begin
            status = ST_SHORT;
        end else if (r_count == CntMax) begin
            status = ST_LONG;
        end else if (crc_cur != rx_crc) begin
            status = ST_CRC;
        end else if (addr_cur != r_own_addr && addr_cur != BROADCAST_ADDR) begin
            status = ST_ADDR;
        end else begin
            status = ST_OK;
        end

        if (func_cur == FUNC_READ_HOLDING) begin
            kind = KIND_READ_HOLDING;
        end else if (func_cur == FUNC_WRITE_MULTIPLE) begin
            kind = KIND_WRITE_MULTIPLE;
        end else begin
            kind = KIND_OTHER;
        end

        o_result.frame_status  = status;
        o_result.slave_address = addr_cur;
        o_result.function_code = func_cur;
        o_result.request_kind  = kind;
        o_result.is_broadcast  = (addr_cur == BROADCAST_ADDR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr <= OWN_ADDR_RESET;
        end else if (i_cfg_we) begin
            r_own_addr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_held0 <= 8'h00;
            r_held1 <= 8'h00;
            r_count <= '0;
            r_addr  <= 8'h00;
            r_func  <= 8'h00;
        end else if (i_accept) begin
            if (i_in_word.frame_end) begin
                r_crc   <= CRC_INIT;
                r_held0 <= 8'h00;
                r_held1 <= 8'h00;
                r_count <= '0;
                r_addr  <= 8'h00;
                r_func  <= 8'h00;
            end else begin
                r_crc   <= crc_cur;
                r_held0 <= r_held1;
                r_held1 <= i_in_word.rx_byte;
                r_addr  <= addr_cur;
                r_func  <= func_cur;
                if (r_count != CntMax) begin
                    r_count <= r_count + CntOne;
                end
            end
        end
    end

endmodule

[design/modbus_rtu_frame_checker_unit.sv]
// Modbus RTU frame checker top level: frame tracking and a two-entry output buffer.
// Throughput: one byte word accepted every cycle while the input is not stalled; the CRC step is combinational.
// The verdict word is registered into the output entry, or into the second entry while the first is held.
// The input stalls only while both output entries hold unread verdicts.
// Reset (synchronous, active low) restarts the frame, sets own address to 1, empties output.
`timescale 1ns / 1ps

module modbus_rtu_frame_checker_unit
    import mrtu_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_word   i_in_word,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  logic       i_out_stall,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic      r_out_valid;
    t_out_word r_out_word;
    logic      r_skid_valid;
    t_out_word r_skid_word;

    logic      in_accept;
    logic      out_take;
    logic      new_result;
    t_out_word result;

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign new_result = in_accept && i_in_word.frame_end;
    assign out_take   = r_out_valid && !i_out_stall;

    mrtu_frame_track #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= new_result;
            end
        end else if (new_result) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else if (new_result) begin
                r_out_word <= result;
            end
        end else if (new_result) begin
            r_skid_word <= result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
